// File: rtl/core/mxps_pkg.sv
// ----------------------------------------------------------------------------
// mxps_pkg: shared definitions for the maximum pair xor search
// Sizes of the value store, digit layout of the serial compare and the
// control bundle between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package mxps_pkg;

  // value and store sizes
  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned MAX_ITEMS  = 256;
  localparam int unsigned ADDR_BITS  = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_BITS   = $clog2(MAX_ITEMS + 1);

  // digit-serial layout, most significant digit first
  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned NUM_DIGITS = (VALUE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PAD_BITS   = NUM_DIGITS * DIGIT_BITS;
  localparam int unsigned DIG_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // stream payload width, whole bytes
  localparam int unsigned TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  // controls from the sequencer to the compare unit
  typedef struct packed {
    logic clear;       // clear the running maximum
    logic load_val;    // take a new item value
    logic load_entry;  // take a stored entry from the store read port
    logic step;        // process one digit
  } cmp_ctrl_t;

endpackage

// File: rtl/core/mxps_store.sv
// ----------------------------------------------------------------------------
// mxps_store: value store
// Single write port and one registered read port over the stored values.
// ----------------------------------------------------------------------------
module mxps_store
  import mxps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_BITS-1:0]  waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0]  raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem_q [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mxps_cmp.sv
// ----------------------------------------------------------------------------
// mxps_cmp: digit-serial xor and compare
// Shifts the item value, one stored entry and the running maximum through
// digit-wide shift registers, msb digit first, and keeps the larger xor.
// ----------------------------------------------------------------------------
module mxps_cmp
  import mxps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmp_ctrl_t             ctrl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] entry_i,
  output logic                  last_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [VALUE_BITS-1:0] best_o
);

  logic [PAD_BITS-1:0]   val_sh_q, val_sh_d;
  logic [PAD_BITS-1:0]   ent_sh_q, ent_sh_d;
  logic [PAD_BITS-1:0]   best_sh_q, best_sh_d;
  logic [PAD_BITS-1:0]   cand_q, cand_d;
  logic [DIG_BITS-1:0]   dig_q, dig_d;
  logic                  eq_q, eq_d;
  logic                  gt_q, gt_d;
  logic [DIGIT_BITS-1:0] x_dig;
  logic [DIGIT_BITS-1:0] b_dig;
  logic                  gt_final;

  // current digits
  assign x_dig    = ent_sh_q[PAD_BITS-1 -: DIGIT_BITS] ^ val_sh_q[PAD_BITS-1 -: DIGIT_BITS];
  assign b_dig    = best_sh_q[PAD_BITS-1 -: DIGIT_BITS];
  assign last_o   = (dig_q == DIG_BITS'(NUM_DIGITS - 1));
  assign gt_final = gt_q | (eq_q & (x_dig > b_dig));

  // shift register and compare state update
  always_comb begin
    val_sh_d  = val_sh_q;
    ent_sh_d  = ent_sh_q;
    best_sh_d = best_sh_q;
    cand_d    = cand_q;
    dig_d     = dig_q;
    eq_d      = eq_q;
    gt_d      = gt_q;
    if (ctrl_i.load_val) begin
      val_sh_d = PAD_BITS'(value_i);
    end
    if (ctrl_i.clear) begin
      best_sh_d = '0;
    end
    if (ctrl_i.load_entry) begin
      ent_sh_d = PAD_BITS'(entry_i);
      dig_d    = '0;
      eq_d     = 1'b1;
      gt_d     = 1'b0;
    end else if (ctrl_i.step) begin
      // value and maximum rotate back to place after a full pass
      val_sh_d = (val_sh_q << DIGIT_BITS) | (val_sh_q >> (PAD_BITS - DIGIT_BITS));
      ent_sh_d = ent_sh_q << DIGIT_BITS;
      cand_d   = (cand_q << DIGIT_BITS) | PAD_BITS'(x_dig);
      if (last_o && gt_final) begin
        best_sh_d = cand_d;
      end else begin
        best_sh_d = (best_sh_q << DIGIT_BITS) | (best_sh_q >> (PAD_BITS - DIGIT_BITS));
      end
      dig_d = dig_q + DIG_BITS'(1);
      if (eq_q) begin
        if (x_dig > b_dig) begin
          gt_d = 1'b1;
          eq_d = 1'b0;
        end else if (x_dig < b_dig) begin
          eq_d = 1'b0;
        end
      end
    end
  end

  // running maximum and digit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sh_q <= '0;
      dig_q     <= '0;
      eq_q      <= 1'b0;
      gt_q      <= 1'b0;
    end else begin
      best_sh_q <= best_sh_d;
      dig_q     <= dig_d;
      eq_q      <= eq_d;
      gt_q      <= gt_d;
    end
  end

  // data shift registers
  always_ff @(posedge clk_i) begin
    val_sh_q <= val_sh_d;
    ent_sh_q <= ent_sh_d;
    cand_q   <= cand_d;
  end

  assign value_o = val_sh_q[VALUE_BITS-1:0];
  assign best_o  = best_sh_q[VALUE_BITS-1:0];

endmodule

// File: rtl/core/max_xor_pair_search_top.sv
// ----------------------------------------------------------------------------
// max_xor_pair_search_top: running maximum xor of any two values in a set
// Each item is xored digit by digit against every stored value of the
// current set; the value is then appended to the store if there is room.
// ----------------------------------------------------------------------------
// scan: n = values stored before the item (0 when first is set); each stored
//   value takes one read, one load and NUM_DIGITS (8) digit steps through the
//   serial compare
// flow: one item at a time; the next item is accepted once the result is in
//   the output register
// reset: clears the stored count, running maximum and output valid

module max_xor_pair_search_top
  import mxps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_BITS-1:0] s_axis_tdata,   // [30:0] value
  input  logic                  s_axis_tuser,   // [0] first
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_BITS-1:0] m_axis_tdata,   // [30:0] running_max
  output logic                  m_axis_tuser    // [0] store_full
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [CNT_BITS-1:0]   idx_q, idx_d;
  logic                  full_q, full_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_max_q, out_max_d;
  logic                  out_full_q, out_full_d;
  logic [CNT_BITS-1:0]   idx_next;
  logic                  in_acc;
  cmp_ctrl_t             cmp_ctrl;
  logic                  cmp_last;
  logic [VALUE_BITS-1:0] cmp_value;
  logic [VALUE_BITS-1:0] cmp_best;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  st_we;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign idx_next      = idx_q + CNT_BITS'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_max_d   = out_max_q;
    out_full_d  = out_full_q;
    cmp_ctrl    = '0;
    st_we       = 1'b0;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmp_ctrl.load_val = 1'b1;
          cmp_ctrl.clear    = s_axis_tuser;
          count_d           = s_axis_tuser ? '0 : count_q;
          idx_d             = '0;
          state_d           = (count_d != '0) ? ST_READ : ST_WRITE;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmp_ctrl.load_entry = 1'b1;
        state_d             = ST_CMP;
      end
      ST_CMP: begin
        cmp_ctrl.step = 1'b1;
        if (cmp_last) begin
          idx_d   = idx_next;
          state_d = (idx_next < count_q) ? ST_READ : ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (count_q < CNT_BITS'(MAX_ITEMS)) begin
          st_we   = 1'b1;
          count_d = count_q + CNT_BITS'(1);
          full_d  = 1'b0;
        end else begin
          full_d  = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_max_d   = cmp_best;
          out_full_d  = full_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_max_q  <= out_max_d;
    out_full_q <= out_full_d;
  end

  mxps_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[ADDR_BITS-1:0]),
    .wdata_i (cmp_value),
    .raddr_i (idx_q[ADDR_BITS-1:0]),
    .rdata_o (rd_data)
  );

  mxps_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cmp_ctrl),
    .value_i (s_axis_tdata[VALUE_BITS-1:0]),
    .entry_i (rd_data),
    .last_o  (cmp_last),
    .value_o (cmp_value),
    .best_o  (cmp_best)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_BITS'(out_max_q);
  assign m_axis_tuser  = out_full_q;

  // store never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(MAX_ITEMS))
    else $error("stored count beyond store depth");

  // scan only reads written entries
  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_LOAD || state_q == ST_CMP) |-> idx_q < count_q)
    else $error("scan index past stored count");

  // full flag only when the store is at capacity
  a_full_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && full_q) |-> count_q == CNT_BITS'(MAX_ITEMS))
    else $error("full flag with room left");

  // no new item while a scan is running
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input ready while busy");

endmodule
